@@ rtl/timed_bit_serializer_macros.svh @@
// Assertion macros used by the checker file of the serializer.
`ifndef TIMED_BIT_SERIALIZER_MACROS_SVH
`define TIMED_BIT_SERIALIZER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("serializer check failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define TBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("serializer check failed: next-cycle implication");

`endif

@@ rtl/tbs_pkg.sv @@
// Types, codes and constants of the timed bit serializer.
package tbs_pkg;

	localparam int unsigned MAX_BITS    = 32;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned SENT_W      = 16;
	localparam int unsigned S_TDATA_W   = 40;
	localparam int unsigned M_TDATA_W   = 24;
	localparam int unsigned ADDR_W      = 4;
	localparam int unsigned APB_DATA_W  = 32;

	// input item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;
	localparam logic [1:0] ST_NOT_BUSY = 2'd3;

	// register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
	localparam logic [1:0] REG_MSB_LEAD   = 2'd1;
	localparam logic [1:0] REG_REST_LEVEL = 2'd2;

	// result item, line_level in the lowest bit
	typedef struct packed {
		logic [SENT_W-1:0] sent_count;
		logic              done_res;
		logic [1:0]        status;
		logic              busy_res;
		logic              line_level;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

endpackage

@@ rtl/timed_bit_serializer.sv @@
// Top level of the timed bit serializer: state, next-state logic and output skid.
//
// Channel   Dir  Handshake         Contents
// s_*       in   tvalid/tready     tdata: tx_word, tx_len; tuser: kind
// m_*       out  tvalid/tready     tdata: line_level, busy_res, status, done_res, sent_count
// APB       in   psel/penable      bit_period, msb_lead, rest_level (addr 0x0, 0x4, 0x8)
//
// Each accepted item updates the transfer state at the edge that accepts it, and the result
// is registered at that same edge, in the output register or, while that one is held, in
// the skid entry, so an item can enter in every cycle while s_tready is high. The two-entry
// output keeps s_tready registered; it drops only once both entries hold unread results.
// arst_n clears the transfer state, the counter and the registers to their reset values.
module timed_bit_serializer (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] tx_word, [37:32] tx_len, [39:38] zero
	input  logic [tbs_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_tuser,
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] line_level, [1] busy_res, [3:2] status, [4] done_res, [20:5] sent_count,
	// [23:21] zero
	output logic [tbs_pkg::M_TDATA_W-1:0]   m_tdata,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tbs_pkg::ADDR_W-1:0]      paddr,
	input  logic [tbs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tbs_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import tbs_pkg::*;

	// configuration registers
	logic [PERIOD_W-1:0] bit_period_q;
	logic                msb_lead_q;
	logic                rest_level_q;

	// transfer state
	logic                active_q;
	logic [DATA_W-1:0]   shift_data_q;
	logic [COUNT_W-1:0]  send_length_q;
	logic [COUNT_W-1:0]  bit_index_q;
	logic [PERIOD_W-1:0] ticks_left_q;
	logic                line_out_q;
	logic [SENT_W-1:0]   completed_q;

	// next-state values
	logic                active_d;
	logic [DATA_W-1:0]   shift_data_d;
	logic [COUNT_W-1:0]  send_length_d;
	logic [COUNT_W-1:0]  bit_index_d;
	logic [PERIOD_W-1:0] ticks_left_d;
	logic                line_out_d;
	logic [SENT_W-1:0]   completed_d;
	logic [1:0]          status_d;
	logic                done_d;

	// output skid
	res_t                res_d;
	res_t                out_q;
	res_t                skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	logic                in_acc;
	logic                out_acc;
	logic                cfg_wr;
	logic [1:0]          cfg_idx;

	logic [1:0]          kind;
	logic [DATA_W-1:0]   tx_word;
	logic [COUNT_W-1:0]  tx_len;
	logic [COUNT_W-1:0]  clamped_count;
	logic [2:0]          bit_pos;
	logic                next_bit;

	assign kind    = s_tuser;
	assign tx_word = s_tdata[DATA_W-1:0];
	assign tx_len  = s_tdata[DATA_W +: COUNT_W];

	assign clamped_count = (tx_len > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : tx_len;

	// bit within the current byte; MSB-first mirrors the position
	assign bit_pos  = bit_index_q[2:0] ^ {3{msb_lead_q}};
	assign next_bit = bit_index_q[COUNT_W-1] ? 1'b0
			: shift_data_q[{bit_index_q[4:3], bit_pos}];

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= PERIOD_W'(1);
			msb_lead_q   <= 1'b1;
			rest_level_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BIT_PERIOD: bit_period_q <= pwdata[PERIOD_W-1:0];
				REG_MSB_LEAD:   msb_lead_q   <= pwdata[0];
				REG_REST_LEVEL: rest_level_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_BIT_PERIOD: prdata = APB_DATA_W'(bit_period_q);
			REG_MSB_LEAD:   prdata = APB_DATA_W'(msb_lead_q);
			REG_REST_LEVEL: prdata = APB_DATA_W'(rest_level_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- next-state logic ----------------
	always_comb begin
		active_d      = active_q;
		shift_data_d  = shift_data_q;
		send_length_d = send_length_q;
		bit_index_d   = bit_index_q;
		ticks_left_d  = ticks_left_q;
		line_out_d    = line_out_q;
		completed_d   = completed_q;
		status_d      = ST_OK;
		done_d        = 1'b0;

		unique case (kind)
			KIND_START: begin
				// zero period is checked ahead of busy
				priority if (bit_period_q == '0) begin
					status_d = ST_INVALID;
				end else if (active_q) begin
					status_d = ST_BUSY;
				end else begin
					shift_data_d  = tx_word;
					send_length_d = clamped_count;
					bit_index_d   = '0;
					active_d      = 1'b1;
					line_out_d    = rest_level_q;
					ticks_left_d  = bit_period_q;
				end
			end
			KIND_ABORT: begin
				if (!active_q) begin
					status_d = ST_NOT_BUSY;
				end else begin
					active_d   = 1'b0;
					line_out_d = rest_level_q;
				end
			end
			KIND_TICK: begin
				if (active_q) begin
					if (ticks_left_q <= PERIOD_W'(1)) begin
						if (bit_index_q < send_length_q) begin
							line_out_d   = next_bit;
							bit_index_d  = bit_index_q + COUNT_W'(1);
							ticks_left_d = bit_period_q;
						end else begin
							// one period after the last bit: back to idle
							line_out_d   = rest_level_q;
							active_d     = 1'b0;
							completed_d  = completed_q + SENT_W'(1);
							done_d       = 1'b1;
							ticks_left_d = '0;
						end
					end else begin
						ticks_left_d = ticks_left_q - PERIOD_W'(1);
					end
				end
			end
			default: ;  // unused kind: no effect
		endcase

		res_d.line_level = line_out_d;
		res_d.busy_res   = active_d;
		res_d.status     = status_d;
		res_d.done_res   = done_d;
		res_d.sent_count = completed_d;
	end

	// ---------------- state registers ----------------
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			shift_data_q  <= '0;
			send_length_q <= '0;
			bit_index_q   <= '0;
			ticks_left_q  <= '0;
			line_out_q    <= 1'b1;
			completed_q   <= '0;
		end else if (in_acc) begin
			active_q      <= active_d;
			shift_data_q  <= shift_data_d;
			send_length_q <= send_length_d;
			bit_index_q   <= bit_index_d;
			ticks_left_q  <= ticks_left_d;
			line_out_q    <= line_out_d;
			completed_q   <= completed_d;
		end
	end

	// ---------------- output register and skid ----------------
	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_acc) begin
				// output register free this cycle: skid drains first
				out_valid_q  <= skid_valid_q || in_acc;
				skid_valid_q <= 1'b0;
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_acc) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end
		if (out_valid_q && !out_acc && in_acc) begin
			skid_q <= res_d;
		end
	end

endmodule

@@ rtl/tbs_checker.sv @@
// Port-level checker for the timed bit serializer, bound to the top level.
`include "timed_bit_serializer_macros.svh"

module tbs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [tbs_pkg::M_TDATA_W-1:0] m_tdata
);
	import tbs_pkg::*;

	// stalled result stays offered
	`TBS_ASSERT_NXT(a_m_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// input side only backs up once a result is waiting
	`TBS_ASSERT_IMP(a_ready_low_needs_out, clk, arst_n, !s_tready, m_tvalid)

	// a completing tick leaves the block idle
	`TBS_ASSERT_IMP(a_done_idle, clk, arst_n, m_tvalid && m_tdata[4], !m_tdata[1])

	// a rejected start reports busy only while a transfer runs
	`TBS_ASSERT_IMP(a_busy_status, clk, arst_n, m_tvalid && (m_tdata[3:2] == ST_BUSY),
		m_tdata[1] && !m_tdata[4])

endmodule

bind timed_bit_serializer tbs_checker u_tbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ bench/tb_timed_bit_serializer.sv @@
`timescale 1ns / 100ps
// Self-checking bench for timed_bit_serializer: stream and APB stimulus with line prediction.
module tb_timed_bit_serializer;
	import tbs_pkg::*;

	// kind code that the block has no use for; it must pass through as a plain report
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int unsigned ITEM_TARGET = 1500;
	localparam int unsigned PHASES = 8;
	localparam int unsigned STALL_CYCLES = 80;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [31:0] tx_word, [37:32] tx_len, [39:38] zero
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	// [1:0] kind
	logic [1:0]             s_tuser = KIND_TICK;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] line_level, [1] busy_res, [3:2] status, [4] done_res, [20:5] sent_count
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	// register shadows, at their reset values
	logic [PERIOD_W-1:0]    cfg_period = 16'd1;
	logic                   cfg_msb = 1'b1;
	logic                   cfg_idle = 1'b1;

	// predicted transfer state, at its reset values
	logic                   xfer_active = 1'b0;
	logic [DATA_W-1:0]      xfer_data = '0;
	logic [COUNT_W-1:0]     xfer_len = '0;
	logic [COUNT_W-1:0]     xfer_idx = '0;
	logic [PERIOD_W-1:0]    ticks_left = '0;
	logic                   line_now = 1'b1;
	logic [SENT_W-1:0]      done_total = '0;

	// line reports still owed by the block, oldest first
	res_t                   due_line_reports[$];
	int unsigned            items_sent = 0;
	int unsigned            mismatches = 0;
	// random idling on both sides; cleared for quiet stretches and the final phase
	logic                   idle_on = 1'b1;
	// long receiver hold-off request, taken up by the sink process
	int unsigned            sink_hold = 0;

	timed_bit_serializer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Steps the predicted serializer by one accepted transaction and returns the report
	// it should produce. Register shadows are read live, as the block does at each
	// expiry and reload.
	function automatic res_t advance_line(logic [1:0] kind, logic [DATA_W-1:0] word,
			logic [COUNT_W-1:0] cnt);
		res_t       r;
		logic [7:0] byte_bits;
		logic [2:0] pos;
		r = '0;
		r.status = ST_OK;
		case (kind)
		KIND_START: begin
			// zero period wins over busy
			if (cfg_period == '0) begin
				r.status = ST_INVALID;
			end else if (xfer_active) begin
				r.status = ST_BUSY;
			end else begin
				xfer_data = word;
				xfer_len = (cnt > MAX_BITS) ? COUNT_W'(MAX_BITS) : cnt;
				xfer_idx = '0;
				xfer_active = 1'b1;
				line_now = cfg_idle;
				ticks_left = cfg_period;
			end
		end
		KIND_ABORT: begin
			if (!xfer_active) begin
				r.status = ST_NOT_BUSY;
			end else begin
				xfer_active = 1'b0;
				line_now = cfg_idle;
			end
		end
		KIND_TICK: begin
			if (xfer_active) begin
				if (ticks_left <= 16'd1) begin
					if (xfer_idx < xfer_len) begin
						// bytes low first; bit order inside a byte set by msb_lead
						if (xfer_idx >= DATA_W) begin
							line_now = 1'b0;
						end else begin
							byte_bits = 8'(xfer_data >> (xfer_idx[4:3] * 8));
							pos = cfg_msb ? 3'd7 - xfer_idx[2:0] : xfer_idx[2:0];
							line_now = byte_bits[pos];
						end
						xfer_idx = xfer_idx + 1'b1;
						ticks_left = cfg_period;
					end else begin
						// one period after the last bit: back to idle, count it
						line_now = cfg_idle;
						xfer_active = 1'b0;
						done_total = done_total + 1'b1;
						r.done_res = 1'b1;
						ticks_left = '0;
					end
				end else begin
					ticks_left = ticks_left - 1'b1;
				end
			end
		end
		default: ;
		endcase
		r.line_level = line_now;
		r.busy_res = xfer_active;
		r.sent_count = done_total;
		return r;
	endfunction

	task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// Result side: every transaction on the master stream is held against the oldest
	// owed report, one field at a time.
	always @(posedge clk) begin : report_watch
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (due_line_reports.size() == 0) begin
				flag_mismatch("unowed transaction", 0, m_tdata);
			end else begin
				want = due_line_reports.pop_front();
				if (got.line_level !== want.line_level)
					flag_mismatch("line_level", want.line_level, got.line_level);
				if (got.busy_res !== want.busy_res)
					flag_mismatch("busy_res", want.busy_res, got.busy_res);
				if (got.status !== want.status)
					flag_mismatch("status", want.status, got.status);
				if (got.done_res !== want.done_res)
					flag_mismatch("done_res", want.done_res, got.done_res);
				if (got.sent_count !== want.sent_count)
					flag_mismatch("sent_count", want.sent_count, got.sent_count);
			end
		end
	end

	// Sink: tready changes on the falling edge only. A hold-off request holds it low for
	// the requested span; otherwise short random stalls while idling is on.
	initial begin : line_sink
		int unsigned span;
		forever begin
			@(negedge clk);
			if (sink_hold != 0) begin
				span = sink_hold;
				sink_hold = 0;
				m_tready <= 1'b0;
				repeat (span - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One transaction on the slave stream. Entered and left at a falling edge; tvalid
	// stays high into the next call unless a random gap is taken.
	task automatic send_item(logic [1:0] kind, logic [DATA_W-1:0] word,
			logic [COUNT_W-1:0] cnt);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, cnt, word};
		do @(posedge clk); while (s_tready !== 1'b1);
		due_line_reports.push_back(advance_line(kind, word, cnt));
		if (kind != KIND_SPARE)
			items_sent++;
		@(negedge clk);
	endtask

	// Sender goes quiet until every owed report has arrived.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (due_line_reports.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// APB write: setup then access; register taken at the edge with pready high.
	task automatic apb_write(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
		REG_BIT_PERIOD: cfg_period = value[PERIOD_W-1:0];
		REG_MSB_LEAD:   cfg_msb = value[0];
		REG_REST_LEVEL: cfg_idle = value[0];
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// All three registers, only once the block has gone quiet. Upper bits are junk.
	task automatic set_config(logic [PERIOD_W-1:0] per, logic msb, logic idle);
		wait_for_results();
		apb_write(REG_BIT_PERIOD, {16'($urandom), per});
		apb_write(REG_MSB_LEAD, {31'($urandom), msb});
		apb_write(REG_REST_LEVEL, {31'($urandom), idle});
	endtask

	// Idle behaviour and a short transfer at the reset settings.
	task automatic test_idle_items();
		send_item(KIND_TICK, 32'hFFFF_FFFF, 6'h3F);
		send_item(KIND_ABORT, '0, '0);
		send_item(KIND_SPARE, 32'h1234_5678, 6'd5);
		send_item(KIND_START, 32'h0000_00A5, 6'd3);
		repeat (4) send_item(KIND_TICK, '0, '0);
	endtask

	// Start and abort rules, zero bit count, longest period, bit order.
	task automatic test_start_rules();
		set_config(16'd0, 1'b1, 1'b1);
		send_item(KIND_START, 32'hDEAD_BEEF, 6'd8);
		// slowest period: a clamped start, a busy start, then aborts busy and idle
		set_config(16'hFFFF, 1'b1, 1'b0);
		send_item(KIND_START, 32'hFFFF_FFFF, 6'h3F);
		repeat (2) send_item(KIND_TICK, '0, '0);
		send_item(KIND_START, '0, 6'd1);
		send_item(KIND_ABORT, '0, '0);
		send_item(KIND_ABORT, '0, '0);
		// zero bit count finishes on the first expiry
		set_config(16'd2, 1'b0, 1'b0);
		send_item(KIND_START, '0, 6'd0);
		repeat (2) send_item(KIND_TICK, '0, '0);
		// LSB first with the line idling high
		set_config(16'd1, 1'b0, 1'b1);
		send_item(KIND_START, 32'h8000_0002, 6'd2);
		repeat (3) send_item(KIND_TICK, '0, '0);
	endtask

	// Receiver holds off for a long stretch while ticks keep coming, so the output
	// buffer fills and the input stalls.
	task automatic test_output_stall();
		set_config(16'd1, 1'b1, 1'b0);
		idle_on = 1'b0;
		sink_hold = STALL_CYCLES;
		send_item(KIND_START, $urandom, 6'd32);
		repeat (40) send_item(KIND_TICK, $urandom, 6'($urandom));
		wait_for_results();
		idle_on = 1'b1;
	endtask

	// A well-formed transfer with random content: start, then ticks until it ends,
	// with the odd abort, busy start or spare code thrown in.
	task automatic run_transfer();
		int unsigned pick;
		logic [COUNT_W-1:0] cnt;
		cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
				: 6'($urandom_range(0, 32));
		send_item(KIND_START, $urandom, cnt);
		while (xfer_active) begin
			pick = $urandom_range(0, 199);
			if (pick == 0)
				send_item(KIND_ABORT, $urandom, 6'($urandom));
			else if (pick < 4)
				send_item(KIND_START, $urandom, 6'($urandom));
			else if (pick < 6)
				send_item(KIND_SPARE, $urandom, 6'($urandom));
			else
				send_item(KIND_TICK, $urandom, 6'($urandom));
		end
	endtask

	// Random phases over several settings; one quiet phase mid-run and the last one
	// without idling at all.
	task automatic test_random_phases();
		int unsigned phase;
		int unsigned stop_at;
		logic [PERIOD_W-1:0] per;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
			0: per = 16'd1;
			1: per = 16'($urandom_range(2, 4));
			2: per = 16'd3;
			default: per = 16'($urandom_range(1, 6));
			endcase
			set_config(per, phase[0], phase[1]);
			idle_on = (phase != 2) && (phase != PHASES - 1);
			stop_at = items_sent + ITEM_TARGET / PHASES;
			while (items_sent < stop_at) begin
				if ($urandom_range(0, 9) != 0)
					run_transfer();
				else
					send_item(2'($urandom_range(0, 3)), $urandom, 6'($urandom));
			end
			// leave the block idle before the next register writes
			if (xfer_active)
				send_item(KIND_ABORT, '0, '0);
		end
	endtask

	initial begin : run_tests
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_items();
		test_start_rules();
		test_output_stall();
		test_random_phases();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && due_line_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
